// File: rtl/core/cvm_pkg.sv
// Shared types and constants for the cell voltage monitor.
`default_nettype none
package cvm_pkg;

    localparam int MV_W    = 13;
    localparam int RAW_W   = 16;
    localparam int TOTAL_W = 21;
    localparam int MIN_W   = 16;
    localparam int CNT_W   = 3;
    localparam int CFG_W   = 13;

    localparam logic [RAW_W-1:0]   ERR_CODE   = 16'hFFFF;
    localparam logic [CNT_W-1:0]   COUNT_MAX  = 3'd7;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 21'h1FFFFF;
    localparam logic [MIN_W-1:0]   MIN_INIT   = 16'hFFFF;
    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam logic [RAW_W-1:0]   DIV10_MUL  = 16'd52429;
    localparam int                 DIV10_SHR  = 19;

    localparam logic [CFG_W-1:0]   MIN_MV_RST = 13'd2500;
    localparam logic [CFG_W-1:0]   MAX_MV_RST = 13'd4200;
    localparam logic [CNT_W-1:0]   LIMIT_RST  = 3'd3;

    typedef enum logic [1:0] {
        REG_MIN_CELL_MV = 2'd0,
        REG_MAX_CELL_MV = 2'd1,
        REG_ERROR_LIMIT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            ok;
        logic            cfault;
        logic            limit_hit;
        logic            last;
    } cell_res_t;

    typedef struct packed {
        logic               pass_done;
        logic [TOTAL_W-1:0] total;
        logic               total_updated;
        logic [MIN_W-1:0]   min_mv;
        logic [MV_W-1:0]    max_mv;
        logic               fault;
    } pack_sum_t;

endpackage
`default_nettype wire

// File: rtl/core/cvm_count_mem.sv
// Per-cell consecutive error count memory with clearing sweep after reset.
`default_nettype none
module cvm_count_mem #(
    parameter int DEPTH = 160,
    parameter int IDX_W = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      rd_en,
    input  wire logic [IDX_W-1:0]          rd_idx,
    output logic      [cvm_pkg::CNT_W-1:0] rd_data,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W-1:0]          wr_idx,
    input  wire logic [cvm_pkg::CNT_W-1:0] wr_data,
    output logic                           busy
);
    import cvm_pkg::*;

    logic [CNT_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] clr_idx_reg;
    logic             clr_busy_reg;

    assign busy = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            if (clr_idx_reg == IDX_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/cvm_pass_accum.sv
// Running pass total, min, max and flags; builds the pass summary.
`default_nettype none
module cvm_pass_accum (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire cvm_pkg::cell_res_t cell_in,
    output cvm_pkg::pack_sum_t      sum
);
    import cvm_pkg::*;

    logic [TOTAL_W-1:0] run_total_reg, run_total_next;
    logic [MIN_W-1:0]   run_min_reg,   run_min_next;
    logic [MV_W-1:0]    run_max_reg,   run_max_next;
    logic               run_err_reg,   run_err_next;
    logic               run_flt_reg,   run_flt_next;
    logic [TOTAL_W-1:0] held_total_reg;
    logic [TOTAL_W:0]   total_wide;

    always_comb begin
        total_wide = {1'b0, run_total_reg} + {{(TOTAL_W + 1 - MV_W){1'b0}}, cell_in.mv};
        run_total_next = run_total_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        if (cell_in.ok) begin
            run_total_next = total_wide[TOTAL_W] ? TOTAL_MAX : total_wide[TOTAL_W-1:0];
            if (MIN_W'(cell_in.mv) < run_min_reg) begin
                run_min_next = MIN_W'(cell_in.mv);
            end
            if (cell_in.mv > run_max_reg) begin
                run_max_next = cell_in.mv;
            end
        end
        run_err_next = run_err_reg | ~cell_in.ok;
        run_flt_next = run_flt_reg | cell_in.cfault | cell_in.limit_hit;

        sum = '0;
        if (cell_in.last) begin
            sum.pass_done     = 1'b1;
            sum.total         = run_err_next ? held_total_reg : run_total_next;
            sum.total_updated = ~run_err_next;
            sum.min_mv        = run_min_next;
            sum.max_mv        = run_max_next;
            sum.fault         = run_flt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_total_reg  <= '0;
            run_min_reg    <= MIN_INIT;
            run_max_reg    <= '0;
            run_err_reg    <= 1'b0;
            run_flt_reg    <= 1'b0;
            held_total_reg <= '0;
        end else if (step) begin
            if (cell_in.last) begin
                run_total_reg <= '0;
                run_min_reg   <= MIN_INIT;
                run_max_reg   <= '0;
                run_err_reg   <= 1'b0;
                run_flt_reg   <= 1'b0;
                if (!run_err_next) begin
                    held_total_reg <= run_total_next;
                end
            end else begin
                run_total_reg <= run_total_next;
                run_min_reg   <= run_min_next;
                run_max_reg   <= run_max_next;
                run_err_reg   <= run_err_next;
                run_flt_reg   <= run_flt_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/cell_voltage_monitor.sv
// Top level of the battery cell voltage window monitor.
//
//  channel  dir  ports                                 content
//  s_       in   s_tvalid s_tready s_tdata s_tlast     one raw cell reading
//  m_       out  m_tvalid m_tready m_tdata m_tlast     per-cell result, pass summary
//  cfg_     in   cfg_wr_en cfg_index cfg_data          threshold and limit writes
//
// One reading per cycle sustained if m_tready is high; a reading reaches m_tvalid via two
// register stages (divide-by-10 multiply and count memory read; count update, output reg).
// The count memory read-modify-write spans two stages; a forwarded last write
// covers back-to-back readings of the same cell.
// After reset, s_tready stays low while all BANKS*CELLS_PER_BANK entries of the
// count memory are cleared. A stalled m_tready holds every stage in place.
`default_nettype none
module cell_voltage_monitor #(
    parameter int BANKS          = 8,
    parameter int CELLS_PER_BANK = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // bank[2:0] cell_req[7:3] raw_reading[23:8]
    input  wire logic        s_tlast,   // last_of_pass
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cell_mv[12:0] reading_ok[13] cell_fault[14] error_limit_hit[15]
    // pack_total_mv[36:16] total_updated[37] pack_min_mv[53:38]
    // pack_max_mv[66:54] pack_fault[67] zero[71:68]
    output logic [71:0]      m_tdata,
    output logic             m_tlast,   // pass_done
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    import cvm_pkg::*;

    localparam int NUM_CELLS = BANKS * CELLS_PER_BANK;
    localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    logic [CFG_W-1:0] min_mv_reg;
    logic [CFG_W-1:0] max_mv_reg;
    logic [CNT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_mv_reg <= MIN_MV_RST;
            max_mv_reg <= MAX_MV_RST;
            limit_reg  <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_CELL_MV: min_mv_reg <= cfg_data;
                REG_MAX_CELL_MV: max_mv_reg <= cfg_data;
                REG_ERROR_LIMIT: limit_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: decode, divide by 10, memory read
    logic [2:0]         in_bank;
    logic [4:0]         in_cell;
    logic [RAW_W-1:0]   in_raw;
    logic               in_range;
    logic [IDX_W-1:0]   in_idx;
    logic [2*RAW_W-1:0] in_prod;
    logic               s_xfer;

    assign in_bank  = s_tdata[2:0];
    assign in_cell  = s_tdata[7:3];
    assign in_raw   = s_tdata[23:8];
    assign in_range = (32'(in_bank) < 32'(BANKS)) && (32'(in_cell) < 32'(CELLS_PER_BANK));
    assign in_idx   = in_range ? IDX_W'(32'(in_bank) * 32'(CELLS_PER_BANK) + 32'(in_cell))
                               : '0;
    assign in_prod  = in_raw * DIV10_MUL;

    logic             s1_valid_reg;
    logic [MV_W-1:0]  s1_mv_reg;
    logic             s1_ok_reg;
    logic             s1_last_reg;
    logic             s1_range_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    logic             out_free;
    logic             s1_adv;
    logic             clr_busy;

    assign out_free = !m_tvalid || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !clr_busy && (!s1_valid_reg || out_free);
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_mv_reg    <= in_prod[2*RAW_W-1:DIV10_SHR];
            s1_ok_reg    <= (in_raw != ERR_CODE);
            s1_last_reg  <= s_tlast;
            s1_range_reg <= in_range;
            s1_idx_reg   <= in_idx;
        end
    end

    // stage 1: count update with forwarding, window check
    logic [CNT_W-1:0] rd_cnt;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_new;
    logic             wr_en;
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_idx_reg;
    logic [CNT_W-1:0] fwd_cnt_reg;
    cell_res_t        cell_res;
    pack_sum_t        pack_sum;

    cvm_count_mem #(
        .DEPTH (NUM_CELLS),
        .IDX_W (IDX_W)
    ) u_count_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_idx  (in_idx),
        .rd_data (rd_cnt),
        .wr_en   (wr_en),
        .wr_idx  (s1_idx_reg),
        .wr_data (cnt_new),
        .busy    (clr_busy)
    );

    always_comb begin
        cnt_cur = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_cnt_reg : rd_cnt;
        cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
        cnt_new = s1_ok_reg ? '0 : cnt_inc;
        wr_en   = s1_adv && s1_range_reg;

        cell_res.mv        = s1_ok_reg ? s1_mv_reg : '0;
        cell_res.ok        = s1_ok_reg;
        cell_res.cfault    = s1_ok_reg && ((s1_mv_reg < min_mv_reg) || (s1_mv_reg > max_mv_reg));
        cell_res.limit_hit = !s1_ok_reg && s1_range_reg && (cnt_inc > limit_reg);
        cell_res.last      = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (wr_en) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_cnt_reg <= cnt_new;
        end
    end

    cvm_pass_accum u_pass_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s1_adv),
        .cell_in (cell_res),
        .sum     (pack_sum)
    );

    // output register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {4'b0, pack_sum.fault, pack_sum.max_mv, pack_sum.min_mv,
                           pack_sum.total_updated, pack_sum.total,
                           cell_res.limit_hit, cell_res.cfault, cell_res.ok, cell_res.mv};
            m_last_reg <= pack_sum.pass_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/core/cvm_checker.sv
// Port-level assertions for the cell voltage monitor, bound to the top level.
`default_nettype none
module cvm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_err_reading_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[13] |-> (m_tdata[12:0] == 13'd0) && !m_tdata[14])
        else $error("error reading carries voltage or window fault");

    a_no_summary_mid_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[67:16] == 52'd0))
        else $error("summary fields set outside pass end");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && (m_tdata[53:38] != 16'hFFFF)
            |-> (m_tdata[53:38] <= {3'b0, m_tdata[66:54]}))
        else $error("pass minimum above maximum");

endmodule

bind cell_voltage_monitor cvm_checker u_cvm_checker (.*);
`default_nettype wire
